### rtl/prft_pkg.sv
// Shared constants, codes and the queue word type of the port rule filter.
package prft_pkg;

  localparam int PORT_W  = 16;
  localparam int PROTO_W = 2;
  localparam int OP_W    = 2;
  localparam int STAT_W  = 2;
  localparam int MASK_W  = 16;

  localparam int RULE_SLOTS_DEF       = 16;
  localparam int BUILTIN_SERVICES_DEF = 16;
  localparam int BUILTIN_MAX          = 16;

  // Queue between classifier and rule engine
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [OP_W-1:0] OP_CHECK  = 2'd0;
  localparam logic [OP_W-1:0] OP_ADD    = 2'd1;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

  localparam logic [PROTO_W-1:0] PR_TCP  = 2'd0;
  localparam logic [PROTO_W-1:0] PR_UDP  = 2'd1;
  localparam logic [PROTO_W-1:0] PR_BOTH = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_PORT_ZERO = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL      = 2'd2;
  localparam logic [STAT_W-1:0] ST_NO_MATCH  = 2'd3;

  // Built-in services, entry i blocked by mask bit i
  localparam logic [PORT_W-1:0] SVC_PORT [BUILTIN_MAX] = '{
    16'd80, 16'd443, 16'd53, 16'd22, 16'd21, 16'd20, 16'd25, 16'd465,
    16'd110, 16'd143, 16'd993, 16'd3389, 16'd123, 16'd23, 16'd1883, 16'd8883
  };
  localparam logic [PROTO_W-1:0] SVC_PROTO [BUILTIN_MAX] = '{
    PR_TCP, PR_TCP, PR_UDP, PR_TCP, PR_TCP, PR_TCP, PR_TCP, PR_TCP,
    PR_TCP, PR_TCP, PR_TCP, PR_TCP, PR_UDP, PR_TCP, PR_TCP, PR_TCP
  };

  // Classified word handed from front to back
  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [PORT_W-1:0]  port;
    logic [PROTO_W-1:0] proto;
    logic               block_flag;
    logic               port_zero;
    logic               builtin_allow;
  } prft_item_t;

endpackage

### rtl/prft_front.sv
// Front end: classify an incoming word against the built-in service list.
module prft_front #(
  parameter int BUILTIN_SERVICES = prft_pkg::BUILTIN_SERVICES_DEF
) (
  input  logic [prft_pkg::OP_W-1:0]    in_operation,
  input  logic [prft_pkg::PORT_W-1:0]  in_port,
  input  logic [prft_pkg::PROTO_W-1:0] in_proto,
  input  logic                         in_block_flag,
  input  logic [prft_pkg::MASK_W-1:0]  builtin_mask,
  output prft_pkg::prft_item_t         item
);
  import prft_pkg::*;

  logic [BUILTIN_SERVICES-1:0] svc_hit;
  logic [BUILTIN_SERVICES-1:0] svc_first;

  always_comb begin
    for (int i = 0; i < BUILTIN_SERVICES; i++) begin
      svc_hit[i] = (in_port == SVC_PORT[i]) &&
                   ((SVC_PROTO[i] == PR_BOTH) || (SVC_PROTO[i] == in_proto));
    end
  end

  // lowest matching entry wins
  assign svc_first = svc_hit & (-svc_hit);

  always_comb begin
    item.op            = in_operation;
    item.port          = in_port;
    item.proto         = in_proto;
    item.block_flag    = in_block_flag;
    item.port_zero     = (in_port == '0);
    item.builtin_allow = ~(|(svc_first & builtin_mask[BUILTIN_SERVICES-1:0]));
  end

endmodule

### rtl/prft_queue.sv
// Short word queue between the classifier and the rule engine.
module prft_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  prft_pkg::prft_item_t push_item,
  output logic                 full,
  input  logic                 pop,
  output logic                 not_empty,
  output prft_pkg::prft_item_t pop_item
);
  import prft_pkg::*;

  prft_item_t              entries_r [QDEPTH];
  logic [QPTR_W-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]       count_r, count_nxt;

  assign full      = (count_r == QCNT_W'(QDEPTH));
  assign not_empty = (count_r != '0);
  assign pop_item  = entries_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

### rtl/prft_back.sv
// Back end: rule table, parallel slot compare and the result register.
module prft_back #(
  parameter int RULE_SLOTS = prft_pkg::RULE_SLOTS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_valid,
  input  prft_pkg::prft_item_t        q_item,
  output logic                        q_pop,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_allowed,
  output logic [prft_pkg::STAT_W-1:0] out_status
);
  import prft_pkg::*;

  logic [RULE_SLOTS-1:0] active_r;
  logic [RULE_SLOTS-1:0] blk_r;
  logic [PORT_W-1:0]     port_r  [RULE_SLOTS];
  logic [PROTO_W-1:0]    proto_r [RULE_SLOTS];

  logic [RULE_SLOTS-1:0] chk_hit, chk_first;
  logic [RULE_SLOTS-1:0] cmp_hit, cmp_first;
  logic [RULE_SLOTS-1:0] free_vec, free_first;
  logic [RULE_SLOTS-1:0] wr_sel, clr_sel;

  logic              out_valid_r, out_valid_nxt;
  logic              out_allowed_r, out_allowed_nxt;
  logic [STAT_W-1:0] out_status_r, out_status_nxt;

  assign q_pop = q_valid && (!out_valid_r || out_ready);

  always_comb begin
    for (int i = 0; i < RULE_SLOTS; i++) begin
      chk_hit[i] = active_r[i] && (port_r[i] == q_item.port) &&
                   ((proto_r[i] == PR_BOTH) || (proto_r[i] == q_item.proto));
      cmp_hit[i] = active_r[i] && (port_r[i] == q_item.port) &&
                   ((proto_r[i] == q_item.proto) || (q_item.proto == PR_BOTH) ||
                    (proto_r[i] == PR_BOTH));
    end
  end

  assign free_vec   = ~active_r;
  assign chk_first  = chk_hit & (-chk_hit);
  assign cmp_first  = cmp_hit & (-cmp_hit);
  assign free_first = free_vec & (-free_vec);

  always_comb begin
    wr_sel          = '0;
    clr_sel         = '0;
    out_allowed_nxt = 1'b0;
    out_status_nxt  = ST_OK;
    unique case (q_item.op)
      OP_CHECK: begin
        out_allowed_nxt = (|chk_hit) ? ~(|(chk_first & blk_r)) : q_item.builtin_allow;
      end
      OP_ADD: begin
        if (q_item.port_zero) begin
          out_status_nxt = ST_PORT_ZERO;
        end else if (|cmp_hit) begin
          wr_sel = cmp_first;
        end else if (|free_vec) begin
          wr_sel = free_first;
        end else begin
          out_status_nxt = ST_FULL;
        end
      end
      OP_REMOVE: begin
        if (|cmp_hit) begin
          clr_sel = cmp_first;
        end else begin
          out_status_nxt = ST_NO_MATCH;
        end
      end
      default: begin
        out_allowed_nxt = 1'b0;
      end
    endcase
    if (!q_pop) begin
      wr_sel  = '0;
      clr_sel = '0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (q_pop) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      active_r    <= (active_r | wr_sel) & ~clr_sel;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < RULE_SLOTS; i++) begin
      if (wr_sel[i]) begin
        port_r[i]  <= q_item.port;
        proto_r[i] <= q_item.proto;
        blk_r[i]   <= q_item.block_flag;
      end
    end
    if (q_pop) begin
      out_allowed_r <= out_allowed_nxt;
      out_status_r  <= out_status_nxt;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_allowed = out_allowed_r;
  assign out_status  = out_status_r;

endmodule

### rtl/port_rule_filter_table.sv
// Top level of the destination-port rule filter.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one word: operation (check,
//   add/update rule, remove rule), port, proto and block_flag. Output channel
//   (out_valid/out_ready) returns one word per input: allowed and status.
//   cfg_wr_en/cfg_wr_data write the 16-bit built-in block mask; write it
//   only while no word is in flight.
// Path: an accepted word is written into the queue, popped by the rule
//   engine once the output register is free or being taken, and its result registered there.
// Throughput: one word per cycle sustained while out_ready is high. The rule
//   engine compares every slot in parallel and updates the table in the same
//   cycle, so each word sees the table exactly as the previous one left it.
// Reset: synchronous, active low; all rule slots go inactive, the mask
//   clears, queue and output register empty.
// Stall: when out_ready is low the result holds in the output register and
//   the two-entry queue keeps taking words until it fills, then in_ready
//   drops.
module port_rule_filter_table #(
  parameter int RULE_SLOTS       = prft_pkg::RULE_SLOTS_DEF,
  parameter int BUILTIN_SERVICES = prft_pkg::BUILTIN_SERVICES_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [prft_pkg::OP_W-1:0]    in_operation,
  input  logic [prft_pkg::PORT_W-1:0]  in_port,
  input  logic [prft_pkg::PROTO_W-1:0] in_proto,
  input  logic                         in_block_flag,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_allowed,
  output logic [prft_pkg::STAT_W-1:0]  out_status,
  input  logic                         cfg_wr_en,
  input  logic [prft_pkg::MASK_W-1:0]  cfg_wr_data
);
  import prft_pkg::*;

  logic [MASK_W-1:0] mask_r;
  prft_item_t        front_item;
  prft_item_t        q_item;
  logic              q_full;
  logic              q_valid;
  logic              q_pop;
  logic              push;

  // Built-in block mask register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= '0;
    end else if (cfg_wr_en) begin
      mask_r <= cfg_wr_data;
    end
  end

  // Accept whenever the queue has room
  assign in_ready = ~q_full;
  assign push     = in_valid && in_ready;

  // Classify: decode and resolve the built-in service verdict up front
  prft_front #(
    .BUILTIN_SERVICES (BUILTIN_SERVICES)
  ) u_front (
    .in_operation  (in_operation),
    .in_port       (in_port),
    .in_proto      (in_proto),
    .in_block_flag (in_block_flag),
    .builtin_mask  (mask_r),
    .item          (front_item)
  );

  // Decouple front from back
  prft_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (front_item),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .pop_item  (q_item)
  );

  // Execute against the rule table and hold the result for the receiver
  prft_back #(
    .RULE_SLOTS (RULE_SLOTS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_allowed (out_allowed),
    .out_status  (out_status)
  );

endmodule
